### rtl/ptfa_pkg.sv
// Shared types, widths and operation codes of the page table frame allocator.
package ptfa_pkg;

  localparam int TABLE_DEPTH      = 256;
  localparam int PAGE_W           = 8;
  localparam int FRAME_W          = 8;
  localparam int COUNT_W          = 9;
  localparam int OP_W             = 2;
  localparam int NUM_FRAMES_DEF   = 16;

  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT     = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a request and start the frame memory read
    logic exec;   // apply the request and load the result register
  } dp_cmd_t;

endpackage

### rtl/ptfa_req_if.sv
// Request and result channel interfaces of the page table frame allocator.
interface ptfa_req_if;
  logic                              valid;
  logic                              ready;
  logic [ptfa_pkg::OP_W-1:0]         op;
  logic [ptfa_pkg::PAGE_W-1:0]       page_number;

  modport source (output valid, output op, output page_number, input ready);
  modport sink   (input valid, input op, input page_number, output ready);
endinterface

interface ptfa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [ptfa_pkg::FRAME_W-1:0]      frame_index;
  logic                              tlb_drop;
  logic [ptfa_pkg::COUNT_W-1:0]      used_count;

  modport source (output valid, output found, output frame_index, output tlb_drop,
                  output used_count, input ready);
  modport sink   (input valid, input found, input frame_index, input tlb_drop,
                  input used_count, output ready);
endinterface

### rtl/ptfa_datapath.sv
// Datapath: page table storage, frame allocation counter and result register.
module ptfa_datapath #(
  parameter int NUM_FRAMES = ptfa_pkg::NUM_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptfa_pkg::dp_cmd_t               cmd,
  input  logic [ptfa_pkg::OP_W-1:0]       in_op,
  input  logic [ptfa_pkg::PAGE_W-1:0]     in_page_number,
  output logic                            out_found,
  output logic [ptfa_pkg::FRAME_W-1:0]    out_frame_index,
  output logic                            out_tlb_drop,
  output logic [ptfa_pkg::COUNT_W-1:0]    out_used_count
);

  localparam int ALLOC_W = $clog2(NUM_FRAMES + 1);

  // Captured request
  logic [ptfa_pkg::OP_W-1:0]    op_r;
  logic [ptfa_pkg::PAGE_W-1:0]  page_r;

  // Table storage
  logic [ptfa_pkg::FRAME_W-1:0] frame_mem [ptfa_pkg::TABLE_DEPTH];
  logic [ptfa_pkg::FRAME_W-1:0] frame_rd_r;
  logic [ptfa_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [ptfa_pkg::TABLE_DEPTH-1:0] used_r, used_nxt;
  logic [ptfa_pkg::COUNT_W-1:0] used_total_r, used_total_nxt;

  // Frames are only ever taken lowest-free first and never released, so the
  // busy bitmap is always a prefix; its fill level stands in for it.
  logic [ALLOC_W-1:0]           alloc_cnt_r, alloc_cnt_nxt;
  logic                         frames_left;
  logic [ptfa_pkg::FRAME_W-1:0] pick_frame;

  // Result register
  logic                         found_r, found_nxt;
  logic [ptfa_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic                         drop_r, drop_nxt;
  logic                         mem_we;

  assign frames_left = alloc_cnt_r < ALLOC_W'(NUM_FRAMES);
  assign pick_frame  = frames_left ? ptfa_pkg::FRAME_W'(alloc_cnt_r)
                                   : ptfa_pkg::FRAME_W'(NUM_FRAMES - 1);
  assign mem_we      = cmd.exec && (op_r == ptfa_pkg::OP_INSERT);

  // Capture the request and read its frame entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      page_r     <= in_page_number;
      frame_rd_r <= frame_mem[in_page_number];
    end
  end

  // Store the allocated frame on insert
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[page_r] <= pick_frame;
    end
  end

  // Decode the request and compute next state and result
  always_comb begin
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    used_total_nxt = used_total_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    found_nxt      = 1'b0;
    frame_nxt      = '0;
    drop_nxt       = 1'b0;
    case (op_r)
      ptfa_pkg::OP_LOOKUP: begin
        if (valid_r[page_r]) begin
          found_nxt = 1'b1;
          frame_nxt = frame_rd_r;
        end
      end
      ptfa_pkg::OP_INSERT: begin
        frame_nxt         = pick_frame;
        valid_nxt[page_r] = 1'b1;
        if (!used_r[page_r]) begin
          used_nxt[page_r] = 1'b1;
          used_total_nxt   = used_total_r + 1'b1;
        end
        if (frames_left) begin
          alloc_cnt_nxt = alloc_cnt_r + 1'b1;
        end
      end
      ptfa_pkg::OP_INVALIDATE: begin
        valid_nxt[page_r] = 1'b0;
        drop_nxt          = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Advance table state on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      used_r       <= '0;
      used_total_r <= '0;
      alloc_cnt_r  <= '0;
    end else if (cmd.exec) begin
      valid_r      <= valid_nxt;
      used_r       <= used_nxt;
      used_total_r <= used_total_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found_r <= found_nxt;
      frame_r <= frame_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign out_found       = found_r;
  assign out_frame_index = frame_r;
  assign out_tlb_drop    = drop_r;
  assign out_used_count  = used_total_r;

  // Allocation never runs past the frame count
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= ALLOC_W'(NUM_FRAMES))
    else $error("allocation count beyond frame count");

  // The used count only grows, and by at most one per request
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (used_total_r == $past(used_total_r)) ||
                 (used_total_r == $past(used_total_r) + 1'b1))
    else $error("used count stepped by more than one");

endmodule

### rtl/ptfa_ctrl.sv
// Controller: request handshake, execute sequencing and result valid.
module ptfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ptfa_pkg::dp_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  // Sequence one request: capture, then execute once the result slot frees
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Capture and execute never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and exec in the same cycle");

  // A captured request always moves to execute
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_EXEC)
    else $error("captured request not in execute");

  // Hold execute while the result slot is occupied
  a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_ready) |=> state_r == ST_EXEC)
    else $error("executed into an occupied result slot");

  // Execute always presents a result
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("execute without a result");

endmodule

### rtl/page_table_frame_allocator.sv
// Top level of the page table frame allocator: controller plus datapath.
//
//   channel  | modport | payload                                   | accepted when
//   in_req   | sink    | op, page_number                           | valid && ready
//   out_rsp  | source  | found, frame_index, tlb_drop, used_count  | valid && ready
//
// Each request is handled in two steps: capture it and read the frame memory
// (registered read port), then apply it and load the result register.
// A new request is taken only once the previous one has executed.
// A result waiting in the output register does not block the next capture;
// execute holds until that result is taken.
// Reset (rst_n low, synchronous) clears all valid and used marks, the used
// count and the frame allocation at once; no clearing pass is needed.
module page_table_frame_allocator #(
  parameter int NUM_FRAMES = ptfa_pkg::NUM_FRAMES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ptfa_req_if.sink   in_req,
  ptfa_rsp_if.source out_rsp
);

  ptfa_pkg::dp_cmd_t cmd;

  ptfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  ptfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_req.op),
    .in_page_number  (in_req.page_number),
    .out_found       (out_rsp.found),
    .out_frame_index (out_rsp.frame_index),
    .out_tlb_drop    (out_rsp.tlb_drop),
    .out_used_count  (out_rsp.used_count)
  );

endmodule
